// ===== rtl/reorder_buffer_pc_match_macros.svh =====
// Assertion macros for the reorder buffer.
`ifndef REORDER_BUFFER_PC_MATCH_MACROS_SVH
`define REORDER_BUFFER_PC_MATCH_MACROS_SVH
`ifndef SYNTHESIS
`define ROB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rob assertion failed");
`define ROB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rob assertion failed");
`else
`define ROB_ASSERT(lbl, prop)
`define ROB_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/rob_pkg.sv =====
// Shared types and codes for the reorder buffer.
`timescale 1ns / 1ps
package rob_pkg;
    localparam logic [1:0] FUNC_ALLOC    = 2'd0;
    localparam logic [1:0] FUNC_MARK     = 2'd1;
    localparam logic [1:0] FUNC_COMPLETE = 2'd2;
    localparam logic [1:0] FUNC_COMMIT   = 2'd3;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] pc;
        logic [7:0]  opcode;
        logic [5:0]  dest;
        logic [7:0]  prev_phys;
        logic [31:0] value;
        logic        complete;
        logic        exception;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic mark;
        logic complete;
    } cell_ctrl_t;
endpackage

// ===== rtl/rob_cell.sv =====
// One reorder buffer slot: holds an entry, shifts towards the head on commit.
`timescale 1ns / 1ps
module rob_cell (
    input  logic               clk,
    input  rob_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               load,
    input  rob_pkg::entry_t    load_entry,
    input  rob_pkg::entry_t    shift_entry,
    input  logic [31:0]        req_pc,
    input  logic [31:0]        req_value,
    input  logic               found_in,
    output logic               found_out,
    output rob_pkg::entry_t    entry
);
    rob_pkg::entry_t entry_reg;
    rob_pkg::entry_t entry_next;
    logic            hit;

    assign hit       = occupied && (entry_reg.pc == req_pc) && !found_in;
    assign found_out = found_in || (occupied && (entry_reg.pc == req_pc));
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = shift_entry;
        end
        else if (load)
        begin
            entry_next = load_entry;
        end
        else if (hit && ctrl.mark)
        begin
            entry_next.exception = 1'b1;
        end
        else if (hit && ctrl.complete)
        begin
            entry_next.value    = req_value;
            entry_next.complete = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end
endmodule

// ===== rtl/reorder_buffer_pc_match.sv =====
// Reorder buffer top level: cell chain, occupancy control and result register.
// One transaction per cycle: a request is taken whenever the result register is
// empty or being drained, and its result appears in the next cycle. Entries sit
// in a row of DEPTH cells with the oldest in cell 0; commit shifts the row by one
// cell, and pc lookups ripple a found flag from the oldest cell to the newest.
`timescale 1ns / 1ps
`include "reorder_buffer_pc_match_macros.svh"
module reorder_buffer_pc_match #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] pc,
    input  logic [7:0]  opcode,
    input  logic [5:0]  dest_reg,
    input  logic [7:0]  prev_phys_reg,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        stall_res,
    output logic [31:0] alloc_id,
    output logic        matched,
    output logic        commit_valid,
    output logic        commit_error,
    output logic [31:0] commit_id,
    output logic [31:0] commit_pc,
    output logic [7:0]  commit_opcode,
    output logic [5:0]  commit_dest_reg,
    output logic [7:0]  commit_prev_phys,
    output logic [31:0] commit_value,
    output logic [2:0]  commit_flags
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [4:0]    cap_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   next_id_reg, next_id_next;
    logic          out_valid_reg;
    logic          stall_reg, matched_reg, cvalid_reg, cerror_reg;
    logic [31:0]   alloc_id_reg;
    logic [2:0]    cflags_reg;
    rob_pkg::entry_t centry_reg;

    logic            accept;
    logic [31:0]     eff_limit;
    logic            full, empty;
    logic            do_alloc, do_commit, flush;
    rob_pkg::cell_ctrl_t ctrl;
    rob_pkg::entry_t alloc_entry;
    rob_pkg::entry_t cells [DEPTH];
    logic [DEPTH:0]  found;
    rob_pkg::entry_t head;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign eff_limit = (32'(cap_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(cap_reg);
    assign full      = 32'(count_reg) >= eff_limit;
    assign empty     = count_reg == '0;
    assign head      = cells[0];

    assign do_alloc  = accept && (func == rob_pkg::FUNC_ALLOC) && !full;
    assign do_commit = accept && (func == rob_pkg::FUNC_COMMIT) && !empty;
    assign flush     = do_commit && head.exception;

    assign ctrl.shift    = do_commit;
    assign ctrl.mark     = accept && (func == rob_pkg::FUNC_MARK);
    assign ctrl.complete = accept && (func == rob_pkg::FUNC_COMPLETE);

    assign next_id_next = do_alloc ? next_id_reg + 32'd1 : next_id_reg;

    always_comb
    begin
        alloc_entry.id        = next_id_next;
        alloc_entry.pc        = pc;
        alloc_entry.opcode    = opcode;
        alloc_entry.dest      = dest_reg;
        alloc_entry.prev_phys = prev_phys_reg;
        alloc_entry.value     = value;
        alloc_entry.complete  = 1'b0;
        alloc_entry.exception = 1'b0;
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rob_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CW'(i) < count_reg),
            .load        (do_alloc && (count_reg == CW'(i))),
            .load_entry  (alloc_entry),
            .shift_entry ((i == DEPTH - 1) ? cells[i] : cells[(i + 1) % DEPTH]),
            .req_pc      (pc),
            .req_value   (value),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .entry       (cells[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_alloc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (flush)
        begin
            count_next = '0;
        end
        else if (do_commit)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= rob_pkg::CAP_RESET;
            count_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stall_reg    <= (func == rob_pkg::FUNC_ALLOC) && full;
            alloc_id_reg <= next_id_next;
            matched_reg  <= ((func == rob_pkg::FUNC_MARK) ||
                             (func == rob_pkg::FUNC_COMPLETE)) && found[DEPTH];
            cvalid_reg   <= do_commit;
            cerror_reg   <= (func == rob_pkg::FUNC_COMMIT) && empty;
            centry_reg   <= do_commit ? head : '0;
            cflags_reg   <= do_commit ? {flush, head.exception, head.complete} : 3'd0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stall_res        = stall_reg;
    assign alloc_id         = alloc_id_reg;
    assign matched          = matched_reg;
    assign commit_valid     = cvalid_reg;
    assign commit_error     = cerror_reg;
    assign commit_id        = centry_reg.id;
    assign commit_pc        = centry_reg.pc;
    assign commit_opcode    = centry_reg.opcode;
    assign commit_dest_reg  = centry_reg.dest;
    assign commit_prev_phys = centry_reg.prev_phys;
    assign commit_value     = centry_reg.value;
    assign commit_flags     = cflags_reg;

    `ROB_ASSERT(a_count_bound, (32'(count_reg) <= 32'(DEPTH)))
    `ROB_ASSERT(a_alloc_grows, do_alloc |=> (count_reg == CW'($past(count_reg) + CW'(1))))
    `ROB_ASSERT(a_flush_empties, flush |=> (count_reg == '0))
    `ROB_ASSERT_RST(a_reset_idle, !rst_n |-> (count_reg == '0) && !out_valid_reg)
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the reorder buffer with pc matching.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] pc;
        logic [7:0]  opcode;
        logic [5:0]  dest;
        logic [7:0]  prev_phys;
        logic [31:0] value;
    } rob_req_t;

    typedef struct packed {
        logic        stall;
        logic [31:0] alloc_id;
        logic        matched;
        logic        cvalid;
        logic        cerror;
        logic [31:0] cid;
        logic [31:0] cpc;
        logic [7:0]  copcode;
        logic [5:0]  cdest;
        logic [7:0]  cprev;
        logic [31:0] cvalue;
        logic [2:0]  cflags;
    } rob_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [31:0] pc = '0;
    logic [7:0]  opcode = '0;
    logic [5:0]  dest_reg = '0;
    logic [7:0]  prev_phys_reg = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        stall_res;
    logic [31:0] alloc_id;
    logic        matched;
    logic        commit_valid;
    logic        commit_error;
    logic [31:0] commit_id;
    logic [31:0] commit_pc;
    logic [7:0]  commit_opcode;
    logic [5:0]  commit_dest_reg;
    logic [7:0]  commit_prev_phys;
    logic [31:0] commit_value;
    logic [2:0]  commit_flags;

    reorder_buffer_pc_match dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .pc(pc), .opcode(opcode), .dest_reg(dest_reg),
        .prev_phys_reg(prev_phys_reg), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .stall_res(stall_res), .alloc_id(alloc_id), .matched(matched),
        .commit_valid(commit_valid), .commit_error(commit_error),
        .commit_id(commit_id), .commit_pc(commit_pc),
        .commit_opcode(commit_opcode), .commit_dest_reg(commit_dest_reg),
        .commit_prev_phys(commit_prev_phys), .commit_value(commit_value),
        .commit_flags(commit_flags)
    );

    always #1 clk = ~clk;

    rob_req_t   req_q[$];
    rob_res_t   expected_q[$];
    logic [31:0] pc_pool[8];

    // shadow buffer state
    rob_pkg::entry_t shadow[16];
    logic [3:0]  shadow_head = '0;
    int          shadow_count = 0;
    logic [31:0] shadow_next_id = '0;
    logic [4:0]  shadow_cap = rob_pkg::CAP_RESET;

    int errors = 0;
    int n_results = 0;
    int n_stalls = 0;
    int n_flushes = 0;
    int n_matches = 0;
    int n_empty_commits = 0;
    bit req_taken = 1'b0;
    int cycle_no = 0;

    function automatic rob_res_t rob_predict(rob_req_t r);
        rob_res_t res;
        int lim;
        int s;
        bit found;
        res = '0;
        lim = (shadow_cap > 16) ? 16 : int'(shadow_cap);
        found = 1'b0;
        s = 0;
        case (r.func)
            rob_pkg::FUNC_ALLOC: begin
                if (shadow_count >= lim)
                    res.stall = 1'b1;
                else
                begin
                    s = (shadow_head + shadow_count) % 16;
                    shadow_next_id++;
                    shadow[s].id = shadow_next_id;
                    shadow[s].pc = r.pc;
                    shadow[s].opcode = r.opcode;
                    shadow[s].dest = r.dest;
                    shadow[s].prev_phys = r.prev_phys;
                    shadow[s].value = r.value;
                    shadow[s].complete = 1'b0;
                    shadow[s].exception = 1'b0;
                    shadow_count++;
                end
            end
            rob_pkg::FUNC_MARK, rob_pkg::FUNC_COMPLETE: begin
                for (int k = 0; k < shadow_count && !found; k++)
                begin
                    s = (shadow_head + k) % 16;
                    if (shadow[s].pc == r.pc)
                        found = 1'b1;
                end
                if (found)
                begin
                    res.matched = 1'b1;
                    if (r.func == rob_pkg::FUNC_MARK)
                        shadow[s].exception = 1'b1;
                    else
                    begin
                        shadow[s].value = r.value;
                        shadow[s].complete = 1'b1;
                    end
                end
            end
            default: begin
                if (shadow_count == 0)
                    res.cerror = 1'b1;
                else
                begin
                    s = shadow_head;
                    res.cvalid = 1'b1;
                    res.cid = shadow[s].id;
                    res.cpc = shadow[s].pc;
                    res.copcode = shadow[s].opcode;
                    res.cdest = shadow[s].dest;
                    res.cprev = shadow[s].prev_phys;
                    res.cvalue = shadow[s].value;
                    res.cflags = {1'b0, shadow[s].exception, shadow[s].complete};
                    shadow_head = shadow_head + 4'd1;
                    shadow_count--;
                    if (shadow[s].exception)
                    begin
                        shadow_count = 0;
                        res.cflags[2] = 1'b1;
                    end
                end
            end
        endcase
        res.alloc_id = shadow_next_id;
        return res;
    endfunction

    // Monitor: compare results first, then predict the transaction taken this edge
    always @(posedge clk)
    begin
        rob_res_t got;
        rob_res_t exp_res;
        rob_req_t r;
        cycle_no++;
        if (cfg_wr_en)
            shadow_cap = cfg_wr_data;
        if (out_valid && out_ready)
        begin
            got = {stall_res, alloc_id, matched, commit_valid, commit_error, commit_id,
                   commit_pc, commit_opcode, commit_dest_reg, commit_prev_phys,
                   commit_value, commit_flags};
            n_results++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (got !== exp_res)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: mismatch\n  exp %p\n  got %p", exp_res, got);
                end
                if (exp_res.stall) n_stalls++;
                if (exp_res.matched) n_matches++;
                if (exp_res.cflags[2]) n_flushes++;
                if (exp_res.cerror) n_empty_commits++;
            end
        end
        req_taken = in_valid && in_ready;
        if (req_taken)
        begin
            r = {func, pc, opcode, dest_reg, prev_phys_reg, value};
            expected_q.push_back(rob_predict(r));
        end
    end

    // Driver: bursts of random length separated by random gaps
    int burst_left = 8;
    int gap_left = 0;
    always @(negedge clk)
    begin
        rob_req_t r;
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                r = req_q.pop_front();
                {func, pc, opcode, dest_reg, prev_phys_reg, value} <= r;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern by window, plus one long hold-off
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (cycle_no == 400)
            hold_left = 80;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            case ((cycle_no / 50) % 3)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
    end

    function automatic rob_req_t make_req(logic [1:0] f, logic [31:0] p, logic [31:0] v);
        rob_req_t r;
        r.func = f;
        r.pc = p;
        r.opcode = 8'($urandom);
        r.dest = 6'($urandom);
        r.prev_phys = 8'($urandom);
        r.value = v;
        return r;
    endfunction

    // Mostly well-formed traffic on a small pc pool; some raw noise
    function automatic rob_req_t rand_req(int commit_weight);
        rob_req_t r;
        int w;
        r = make_req(rob_pkg::FUNC_ALLOC, pc_pool[$urandom_range(0, 7)], $urandom);
        if ($urandom_range(0, 99) < 12)
        begin
            r.func = 2'($urandom);
            r.pc = $urandom;
            return r;
        end
        w = $urandom_range(0, 99);
        if (w < 40) r.func = rob_pkg::FUNC_ALLOC;
        else if (w < 48) r.func = rob_pkg::FUNC_MARK;
        else if (w < 100 - commit_weight) r.func = rob_pkg::FUNC_COMPLETE;
        else r.func = rob_pkg::FUNC_COMMIT;
        return r;
    endfunction

    task automatic write_capacity(logic [4:0] cap);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (req_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [4:0] caps[7];
        int cweight[7];
        caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd16, 5'd5, 5'd9};
        cweight = '{25, 25, 30, 10, 25, 20, 30};
        for (int i = 0; i < 8; i++)
            pc_pool[i] = $urandom;
        pc_pool[0] = 32'h0;
        pc_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_capacity(5'd16);
        // directed: empty cases, field extremes, duplicate pcs, complete, exception flush
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_MARK, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMPLETE, 32'h0, 32'h1));
        req_q.push_back('{rob_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 8'hFF, 6'h3F, 8'hFF,
                          32'hFFFF_FFFF});
        req_q.push_back('{rob_pkg::FUNC_ALLOC, 32'h0, 8'h00, 6'h00, 8'h00, 32'h0});
        req_q.push_back(make_req(rob_pkg::FUNC_ALLOC, 32'h0, 32'h1234_5678));
        req_q.push_back(make_req(rob_pkg::FUNC_COMPLETE, 32'h0, 32'hDEAD_BEEF));
        req_q.push_back(make_req(rob_pkg::FUNC_COMPLETE, 32'h0, 32'hA5A5_5A5A));
        req_q.push_back(make_req(rob_pkg::FUNC_MARK, 32'h7777_7777, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_MARK, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMPLETE, 32'h0, 32'h5555_AAAA));
        req_q.push_back(make_req(rob_pkg::FUNC_ALLOC, 32'h10, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_ALLOC, 32'h20, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        for (int i = 0; i < 18; i++)
            req_q.push_back(make_req(rob_pkg::FUNC_ALLOC, $urandom, $urandom));
        req_q.push_back(make_req(rob_pkg::FUNC_COMMIT, 32'h0, 32'h0));
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_capacity(caps[ph]);
            for (int i = 0; i < 100; i++)
                req_q.push_back(rand_req(cweight[ph]));
            drain();
        end

        $display("Ran %0d transactions over 8 capacity settings: %0d stalls, %0d matches,",
                 n_results, n_stalls, n_matches);
        $display("%0d flushes, %0d commits on empty; %0d mismatches",
                 n_flushes, n_empty_commits, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule
